/* hdl/rmg_pkg.sv */
// ----------------------------------------------------------------------------
// rmg_pkg: shared types and constants of the row maze generator
// Field widths, register indexes, FSM codes and the control / pick bundles
// that travel between the top level, the column lanes and the merge stage.
// ----------------------------------------------------------------------------
package rmg_pkg;

  localparam int CHOICE_W = 32;  // width of the choice and wall vectors
  localparam int COL_W    = 5;   // column index / set label width
  localparam int CNT_W    = 6;   // column count, up to 32
  localparam int ROW_W    = 16;  // row counter and height
  localparam int CFG_W    = 16;  // widest config register
  localparam int REGIDX_W = 1;

  localparam logic [REGIDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [REGIDX_W-1:0] REG_ROWS    = 1'b1;

  localparam logic [CNT_W-1:0] MIN_COLUMNS   = 6'd2;
  localparam logic [CNT_W-1:0] RESET_COLUMNS = 6'd32;
  localparam logic [ROW_W-1:0] RESET_ROWS    = 16'd32;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_VSCAN = 5'b00010,
    ST_VFIN  = 5'b00100,
    ST_MERGE = 5'b01000,
    ST_DONE  = 5'b10000
  } rmg_state_t;

  // broadcast from the sequencer to every lane
  typedef struct packed {
    logic             vstart;     // clear scan flags
    logic             vscan;      // compare against the broadcast column
    logic [COL_W-1:0] key_idx;
    logic [COL_W-1:0] key_label;
    logic             key_up;
    logic             vfinish;    // resolve up wall and fresh set
    logic             first_row;
    logic             merge;      // rename set m_from to m_to
    logic [COL_W-1:0] m_from;
    logic [COL_W-1:0] m_to;
    logic             store;      // write set back as next-row label
    logic [CNT_W-1:0] width;
  } rmg_ctl_t;

  // what the merge stage picks out of the lanes for the current column
  typedef struct packed {
    logic [COL_W-1:0] key_label;
    logic             key_up;
    logic [COL_W-1:0] left_set;
    logic [COL_W-1:0] right_set;
    logic             do_join;
  } rmg_pick_t;

endpackage

/* hdl/rmg_lane.sv */
// ----------------------------------------------------------------------------
// rmg_lane: one maze column
// Holds the column's carried label and current set, watches the broadcast
// column during the vertical scan and follows set renames during the merge.
// ----------------------------------------------------------------------------
module rmg_lane import rmg_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  rmg_ctl_t         ctl,
  input  logic             up_bit,
  output logic             up_open,
  output logic [COL_W-1:0] cur,
  output logic [COL_W-1:0] label
);

  localparam logic [COL_W-1:0] ME   = COL_W'(IDX);
  localparam logic [CNT_W-1:0] ME_N = CNT_W'(IDX);

  logic             not_last;   // a later column shares the label
  logic             found;      // an earlier same-label column opens up
  logic [COL_W-1:0] found_idx;
  logic             active;
  logic             opens;

  assign active = ME_N < ctl.width;
  assign opens  = active && !ctl.first_row && (up_bit || (!not_last && !found));

  always_ff @(posedge clk) begin
    if (ctl.vstart) begin
      not_last <= 1'b0;
      found    <= 1'b0;
    end else if (ctl.vscan && ctl.key_label == label) begin
      if (ctl.key_idx > ME) not_last <= 1'b1;
      if (ctl.key_idx < ME && ctl.key_up && !found) begin
        found     <= 1'b1;
        found_idx <= ctl.key_idx;
      end
    end

    if (ctl.vfinish) begin
      up_open <= opens;
      // set named by its first upward opener; fresh cells name themselves
      cur     <= (opens && found) ? found_idx : ME;
    end else if (ctl.merge && cur == ctl.m_from) begin
      cur <= ctl.m_to;
    end

    if (ctl.store) label <= active ? cur : ME;
  end

endmodule

/* hdl/rmg_merge.sv */
// ----------------------------------------------------------------------------
// rmg_merge: column pick and join decision
// Selects the scanned column's label and choice bit, and the two neighbor
// sets at the merge position, deciding whether they join.
// ----------------------------------------------------------------------------
module rmg_merge import rmg_pkg::*; #(
  parameter int NCOL = 32
) (
  input  logic [NCOL-1:0][COL_W-1:0] cur_vec,
  input  logic [NCOL-1:0][COL_W-1:0] label_vec,
  input  logic [CHOICE_W-1:0]        up_choice,
  input  logic [CHOICE_W-1:0]        right_choice,
  input  logic [COL_W-1:0]           col,
  input  logic                       last_row,
  output rmg_pick_t                  pick
);

  localparam int LW = (NCOL > 1) ? $clog2(NCOL) : 1;

  logic [COL_W-1:0] col_m1;

  assign col_m1 = col - 1'b1;

  always_comb begin
    pick.key_label = label_vec[col[LW-1:0]];
    pick.key_up    = up_choice[col];
    pick.left_set  = cur_vec[col_m1[LW-1:0]];
    pick.right_set = cur_vec[col[LW-1:0]];
    pick.do_join   = (pick.left_set != pick.right_set) &&
                     (right_choice[col_m1] || last_row);
  end

endmodule

/* hdl/row_maze_generator_unit.sv */
// ----------------------------------------------------------------------------
// row_maze_generator_unit: row-by-row maze generator (Eller's scheme)
// Each input beat is one row of random choice bits; each output beat gives
// that row's open walls, its row index and a last-row flag.
// ----------------------------------------------------------------------------
// A row runs from accept to result through the vertical scan (skipped on the
// first row of a maze), a finish step and the left-to-right merge, over the
// clamped column count: one lane per column works in parallel, and both
// scans step one column per cycle. In the vertical scan each lane compares its
// carried label against the broadcast column; in the merge each join renames a
// whole set at once across the lanes. A new row is accepted in the cycle
// after a result is handed to the output register, even while that
// result still waits for the sink. Config writes take effect on the next
// accepted row; write them only while the block is idle.
// ----------------------------------------------------------------------------
module row_maze_generator_unit import rmg_pkg::*; #(
  parameter int MAX_COLUMNS = 32
) (
  input  logic                clk,
  input  logic                rst,
  // config write port
  input  logic                cfg_we,
  input  logic [REGIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // row choices in: [31:0] up_choice, [63:32] right_choice
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,
  // row walls out: [31:0] up_open, [63:32] right_open, [79:64] row_number
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [79:0]         m_tdata,
  output logic                m_tlast     // maze_done
);

  // lanes: never more than the choice vectors can address
  localparam int NCOL = (MAX_COLUMNS < CHOICE_W) ? MAX_COLUMNS : CHOICE_W;
  localparam logic [CNT_W-1:0] NCOL_N = CNT_W'(NCOL);

  // config registers
  logic [CNT_W-1:0] columns_in_use;
  logic [ROW_W-1:0] rows_in_use;

  // row state
  rmg_state_t       state, state_next;
  logic [ROW_W-1:0] row_counter;
  logic [COL_W-1:0] col;
  logic [CNT_W-1:0] width;        // clamped width of the row in flight
  logic             last_row;
  logic             first_row;
  logic [ROW_W-1:0] row_id;
  logic [CHOICE_W-1:0] up_choice, right_choice, right_acc;

  // output beat
  logic [CHOICE_W-1:0] out_up, out_right;
  logic [ROW_W-1:0]    out_row;
  logic                out_last;

  logic             accept, load_out, col_at_end;
  logic [CNT_W-1:0] width_now;
  logic [ROW_W-1:0] height;
  logic             last_now;
  rmg_ctl_t         ctl;
  rmg_pick_t        pick;

  logic [NCOL-1:0][COL_W-1:0] cur_vec, label_vec;
  logic [NCOL-1:0]            lane_up;
  logic [CHOICE_W-1:0]        up_vec;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load_out = (state == ST_DONE) && (!m_tvalid || m_tready);

  // width clamp and last-row test, both from the live config
  always_comb begin
    if (columns_in_use < MIN_COLUMNS)  width_now = MIN_COLUMNS;
    else if (columns_in_use > NCOL_N)  width_now = NCOL_N;
    else                               width_now = columns_in_use;
  end
  assign height   = (rows_in_use == '0) ? ROW_W'(1) : rows_in_use;
  assign last_now = ({1'b0, row_counter} + 17'd1) >= {1'b0, height};

  assign col_at_end = ({1'b0, col} == (width - 1'b1));

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= RESET_COLUMNS;
      rows_in_use    <= RESET_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: columns_in_use <= cfg_data[CNT_W-1:0];
        REG_ROWS:    rows_in_use    <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = (row_counter == '0) ? ST_VFIN : ST_VSCAN;
      ST_VSCAN: if (col_at_end) state_next = ST_VFIN;
      ST_VFIN:  state_next = ST_MERGE;
      ST_MERGE: if (col_at_end) state_next = ST_DONE;
      ST_DONE:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      row_counter <= '0;
      col         <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        row_counter <= last_now ? '0 : row_counter + 1'b1;
        col         <= '0;
      end else if (state == ST_VSCAN) begin
        col <= col + 1'b1;
      end else if (state == ST_VFIN) begin
        col <= COL_W'(1);   // merge scan starts at the first pair
      end else if (state == ST_MERGE) begin
        col <= col + 1'b1;
      end
    end
  end

  // row payload, captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      up_choice    <= s_tdata[31:0];
      right_choice <= s_tdata[63:32];
      width        <= width_now;
      last_row     <= last_now;
      first_row    <= (row_counter == '0);
      row_id       <= row_counter;
      right_acc    <= '0;
    end else if (state == ST_MERGE && pick.do_join) begin
      right_acc[col - 1'b1] <= 1'b1;
    end
  end

  // broadcast to lanes
  always_comb begin
    ctl.vstart    = accept;
    ctl.vscan     = (state == ST_VSCAN);
    ctl.key_idx   = col;
    ctl.key_label = pick.key_label;
    ctl.key_up    = pick.key_up;
    ctl.vfinish   = (state == ST_VFIN);
    ctl.first_row = first_row;
    ctl.merge     = (state == ST_MERGE) && pick.do_join;
    // set names are their lowest column; the joined set keeps the lower one
    ctl.m_from    = (pick.left_set < pick.right_set) ? pick.right_set : pick.left_set;
    ctl.m_to      = (pick.left_set < pick.right_set) ? pick.left_set : pick.right_set;
    ctl.store     = (state == ST_DONE);
    ctl.width     = width;
  end

  for (genvar i = 0; i < NCOL; i++) begin : g_lane
    rmg_lane #(.IDX(i)) u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .up_bit  (up_choice[i]),
      .up_open (lane_up[i]),
      .cur     (cur_vec[i]),
      .label   (label_vec[i])
    );
  end

  rmg_merge #(.NCOL(NCOL)) u_merge (
    .cur_vec      (cur_vec),
    .label_vec    (label_vec),
    .up_choice    (up_choice),
    .right_choice (right_choice),
    .col          (col),
    .last_row     (last_row),
    .pick         (pick)
  );

  assign up_vec = CHOICE_W'(lane_up);

  // output register: holds one finished row while the next one runs
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_up    <= up_vec;
      out_right <= right_acc;
      out_row   <= row_id;
      out_last  <= last_row;
    end
  end

  assign m_tdata = {out_row, out_right, out_up};
  assign m_tlast = out_last;

  // scans never step past the clamped width
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VSCAN || state == ST_MERGE) |-> ({1'b0, col} < width))
    else $error("column scan past row width");

  // no wall opens outside the maze, and the last column never opens right
  a_walls_in_width: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |->
      ((up_vec >> width) == '0) && ((right_acc >> (width - 1'b1)) == '0))
    else $error("wall opened beyond maze width");

  // first row of a maze has no upward passages
  a_first_row_closed: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[79:64] == '0) |-> (m_tdata[31:0] == '0))
    else $error("upward passage on first row");

endmodule
